// ===== hdl/noc_latency_completion_queue_macros.svh =====
// assertion macros shared by the checker of the noc latency completion queue
// no dependencies
`ifndef NOC_LATENCY_COMPLETION_QUEUE_MACROS_SVH
`define NOC_LATENCY_COMPLETION_QUEUE_MACROS_SVH

// same-cycle implication
`define NLCQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define NLCQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/nlcq_pkg.sv =====
// shared types, constants and helpers of the noc latency completion queue
// no dependencies
package nlcq_pkg;

    localparam int QUEUE_DEPTH_DEF = 64;
    localparam int PKT_FLITS       = 20;
    localparam int SATURATED_WAIT  = 1000;
    localparam int OUT_MAX         = 64;

    localparam int ARR_W   = 48;
    localparam int LAT_W   = 32;
    localparam int NODE_W  = 8;
    localparam int STAMP_W = 32;
    localparam int SUM_W   = 48;

    typedef enum logic [1:0] {
        KIND_ACCEPTED  = 2'd0,
        KIND_DELIVERED = 2'd1,
        KIND_DROPPED   = 2'd2
    } t_kind;

    localparam logic [1:0] REG_MODE = 2'd0;
    localparam logic [1:0] REG_DIM  = 2'd1;
    localparam logic [1:0] REG_HOP  = 2'd2;
    localparam logic [1:0] REG_RATE = 2'd3;

    localparam logic       MODE_RST = 1'b0;
    localparam logic [4:0] DIM_RST  = 5'd8;
    localparam logic [7:0] HOP_RST  = 8'd1;
    localparam logic [15:0] RATE_RST = 16'd0;

    typedef struct packed {
        logic [ARR_W-1:0]   arrival;
        logic [LAT_W-1:0]   latency;
        logic [NODE_W-1:0]  node;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // earlier arrival first, ties broken by serial-number stamp order
    function automatic logic earlier(input t_entry a, input t_entry b);
        logic [STAMP_W-1:0] d;
        d = a.stamp - b.stamp;
        if (a.arrival != b.arrival) begin
            return a.arrival < b.arrival;
        end
        return d[STAMP_W-1];
    endfunction

endpackage

// ===== hdl/nlcq_ram.sv =====
// generic single write, single read ram with registered read data
// no dependencies
module nlcq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== hdl/noc_latency_completion_queue.sv =====
// Inject: computes the accepted/dropped result in zero-load mode, or in M/D/1 mode (unless
// saturated, with two passes of the shared restoring divider), then sifts an accepted entry up.
// Tick: checks the heap top for a due event and, for each popped event, runs the sift-down
// over the single read port of the heap ram. One item in flight at a time.
// Reset is synchronous, active low: clears counters, sums, config and control; heap ram is
// not cleared since entries past the fill count are never used.
module noc_latency_completion_queue
    import nlcq_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // slave stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // src_col[3:0], src_row[7:4], dst_col[11:8], dst_row[15:12],
    // created_at[63:16], now_cycle[111:64]
    input  logic [111:0] i_s_tdata,
    input  logic         i_s_tuser,    // cmd
    // master stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // node_id[7:0], latency[39:8], saturated[40], latency_total[88:41],
    // delivered_count[136:89], zero pad[143:137]
    output logic [143:0] o_m_tdata,
    output logic [1:0]   o_m_tuser,    // kind
    output logic         o_m_tlast,
    // config port
    input  logic         i_psel,
    input  logic         i_penable,
    input  logic         i_pwrite,
    input  logic [3:0]   i_paddr,
    input  logic [31:0]  i_pwdata,
    output logic [31:0]  o_prdata,
    output logic         o_pready
);

    localparam int AW     = $clog2(QUEUE_DEPTH);
    localparam int CW     = $clog2(QUEUE_DEPTH + 1);
    localparam int DNW    = 40;
    localparam int DRW    = 21;
    localparam int DENW   = 20;
    localparam int DLY_W  = 14;
    localparam int WAIT_W = 30;
    localparam logic [5:0] DIV_LAST = 6'(DNW - 1);

    typedef enum logic [19:0] {
        S_IDLE    = 20'h00001,
        S_CALC    = 20'h00002,
        S_MDC     = 20'h00004,
        S_MDCHK   = 20'h00008,
        S_DIVS    = 20'h00010,
        S_DIVC    = 20'h00020,
        S_MDMUL   = 20'h00040,
        S_MDWAIT  = 20'h00080,
        S_FIN     = 20'h00100,
        S_OUT     = 20'h00200,
        S_SURD    = 20'h00400,
        S_SUCMP   = 20'h00800,
        S_POPRD   = 20'h01000,
        S_POPCMP  = 20'h02000,
        S_POPLAST = 20'h04000,
        S_SDX     = 20'h08000,
        S_SDL     = 20'h10000,
        S_SDR     = 20'h20000,
        S_SDCMP   = 20'h40000,
        S_FLUSH   = 20'h80000
    } t_state;

    // control
    t_state r_state, n_state;
    logic r_mode, n_mode;
    logic [4:0] r_dim, n_dim;
    logic [7:0] r_phd, n_phd;
    logic [15:0] r_rate, n_rate;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [STAMP_W-1:0] r_stamp, n_stamp;
    logic [SUM_W-1:0] r_sum_lat, n_sum_lat, r_sum_del, n_sum_del;
    logic r_out_v, n_out_v;
    logic r_pv, n_pv;
    logic [6:0] r_npop, n_npop;
    logic [5:0] r_dcnt, n_dcnt;

    // payload
    logic [3:0] r_sc, n_sc, r_sr, n_sr, r_dc, n_dc, r_dr, n_dr;
    logic [ARR_W-1:0] r_created, n_created, r_now, n_now, r_q, n_q, r_arr, n_arr;
    logic [4:0] r_hops, n_hops;
    logic [NODE_W-1:0] r_node, n_node;
    logic [DLY_W-1:0] r_delay, n_delay;
    logic [20:0] r_s, n_s;
    logic [25:0] r_c, n_c;
    logic r_sat, n_sat;
    logic [DNW-1:0] r_dnum, n_dnum, r_ws, n_ws, r_wc, n_wc;
    logic [DRW-1:0] r_drem, n_drem;
    logic [DENW-1:0] r_den, n_den;
    logic [44:0] r_hwc, n_hwc;
    logic [WAIT_W-1:0] r_wait, n_wait;
    logic [LAT_W-1:0] r_lat, n_lat;
    t_entry r_x, n_x, r_lc, n_lc;
    logic [AW-1:0] r_i, n_i;
    logic r_hasr, n_hasr;
    logic [NODE_W-1:0] r_p_node, n_p_node;
    logic [LAT_W-1:0] r_p_lat, n_p_lat;
    logic [SUM_W-1:0] r_p_tot, n_p_tot, r_p_cnt, n_p_cnt;
    t_kind r_o_kind, n_o_kind;
    logic [NODE_W-1:0] r_o_node, n_o_node;
    logic [LAT_W-1:0] r_o_lat, n_o_lat;
    logic r_o_sat, n_o_sat, r_o_last, n_o_last;
    logic [SUM_W-1:0] r_o_tot, n_o_tot, r_o_cnt, n_o_cnt;

    // heap ram
    logic w_we;
    logic [AW-1:0] w_waddr, w_raddr;
    t_entry w_wdata, w_rdata;
    logic [ENTRY_W-1:0] w_rbits;

    // helpers
    logic w_out_free, w_cfg_wr;
    logic [3:0] w_cabs, w_rabs;
    logic [9:0] w_node10;
    logic [DRW-1:0] w_rem_sh, w_rem_dif;
    logic w_ge;
    logic [DNW-1:0] w_dnum_nx, w_wc_num;
    logic [DRW-1:0] w_drem_nx;
    logic [DNW-1:0] w_s_half, w_c_half;
    logic [45:0] w_wsum;
    logic [48:0] w_full, w_arr;
    logic w_due, w_lbest, w_rbest;
    logic [AW:0] w_l, w_r;
    logic [AW-1:0] w_par;

    nlcq_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_heap (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rbits)
    );
    assign w_rdata = t_entry'(w_rbits);

    assign o_s_tready = (r_state == S_IDLE);
    assign o_m_tvalid = r_out_v;
    assign o_m_tuser  = r_o_kind;
    assign o_m_tlast  = r_o_last;
    assign o_m_tdata  = {7'd0, r_o_cnt, r_o_tot, r_o_sat, r_o_lat, r_o_node};
    assign o_pready   = 1'b1;

    assign w_out_free = !r_out_v || i_m_tready;
    assign w_cfg_wr   = i_psel && i_penable && i_pwrite;

    always_comb begin
        unique case (i_paddr[3:2])
            REG_MODE: o_prdata = {31'd0, r_mode};
            REG_DIM:  o_prdata = {27'd0, r_dim};
            REG_HOP:  o_prdata = {24'd0, r_phd};
            REG_RATE: o_prdata = {16'd0, r_rate};
            default:  o_prdata = '0;
        endcase
    end

    // shared restoring divider step, one quotient bit per cycle
    assign w_rem_sh  = {r_drem[DRW-2:0], r_dnum[DNW-1]};
    assign w_ge      = w_rem_sh >= DRW'(r_den);
    assign w_rem_dif = w_rem_sh - DRW'(r_den);
    assign w_drem_nx = w_ge ? w_rem_dif : w_rem_sh;
    assign w_dnum_nx = {r_dnum[DNW-2:0], w_ge};

    assign w_s_half = DNW'(65536) - DNW'(r_s);
    assign w_c_half = DNW'(262144) - DNW'(r_c);
    assign w_wc_num = ((DNW'(r_c) * DNW'(PKT_FLITS)) << 16) + w_c_half;

    assign w_cabs   = (r_sc > r_dc) ? r_sc - r_dc : r_dc - r_sc;
    assign w_rabs   = (r_sr > r_dr) ? r_sr - r_dr : r_dr - r_sr;
    assign w_node10 = 10'(r_sr) * 10'(r_dim) + 10'(r_sc);
    assign w_wsum   = 46'(r_ws) + 46'(r_hwc) + 46'(32768);

    always_comb begin
        if (r_mode) begin
            w_full = 49'(r_wait) + 49'(r_delay);
            w_arr  = 49'(r_created) + w_full;
        end else begin
            w_full = 49'(r_q) + 49'(r_delay);
            w_arr  = 49'(r_now) + 49'(r_delay);
        end
    end

    assign w_due   = (r_cnt != '0) && (w_rdata.arrival <= r_now) && (r_npop != 7'(OUT_MAX));
    assign w_l     = {r_i, 1'b1};
    assign w_r     = w_l + (AW+1)'(1);
    assign w_par   = AW'((r_i - AW'(1)) >> 1);
    assign w_lbest = earlier(r_lc, r_x);
    assign w_rbest = r_hasr && earlier(w_rdata, w_lbest ? r_lc : r_x);

    always_comb begin
        n_state = r_state;
        n_mode = r_mode; n_dim = r_dim; n_phd = r_phd; n_rate = r_rate;
        n_cnt = r_cnt; n_stamp = r_stamp; n_sum_lat = r_sum_lat; n_sum_del = r_sum_del;
        n_out_v = r_out_v && !i_m_tready;
        n_pv = r_pv; n_npop = r_npop; n_dcnt = r_dcnt;
        n_sc = r_sc; n_sr = r_sr; n_dc = r_dc; n_dr = r_dr;
        n_created = r_created; n_now = r_now; n_q = r_q; n_arr = r_arr;
        n_hops = r_hops; n_node = r_node; n_delay = r_delay; n_s = r_s; n_c = r_c;
        n_sat = r_sat; n_dnum = r_dnum; n_ws = r_ws; n_wc = r_wc; n_drem = r_drem;
        n_den = r_den; n_hwc = r_hwc; n_wait = r_wait; n_lat = r_lat;
        n_x = r_x; n_lc = r_lc; n_i = r_i; n_hasr = r_hasr;
        n_p_node = r_p_node; n_p_lat = r_p_lat; n_p_tot = r_p_tot; n_p_cnt = r_p_cnt;
        n_o_kind = r_o_kind; n_o_node = r_o_node; n_o_lat = r_o_lat; n_o_sat = r_o_sat;
        n_o_last = r_o_last; n_o_tot = r_o_tot; n_o_cnt = r_o_cnt;
        w_we = 1'b0; w_waddr = r_i; w_wdata = r_x; w_raddr = '0;

        if (w_cfg_wr) begin
            unique case (i_paddr[3:2])
                REG_MODE: n_mode = i_pwdata[0];
                REG_DIM:  n_dim  = i_pwdata[4:0];
                REG_HOP:  n_phd  = i_pwdata[7:0];
                REG_RATE: n_rate = i_pwdata[15:0];
                default:  n_mode = r_mode;
            endcase
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_sc = i_s_tdata[3:0];
                    n_sr = i_s_tdata[7:4];
                    n_dc = i_s_tdata[11:8];
                    n_dr = i_s_tdata[15:12];
                    n_created = i_s_tdata[63:16];
                    n_now = i_s_tdata[111:64];
                    n_npop = '0;
                    n_state = i_s_tuser ? S_POPRD : S_CALC;
                end
            end
            S_CALC: begin
                n_hops  = 5'(w_cabs) + 5'(w_rabs);
                n_node  = w_node10[7:0];
                n_delay = DLY_W'(r_phd) * DLY_W'(5'(w_cabs) + 5'(w_rabs))
                        + DLY_W'(PKT_FLITS - 1);
                n_s     = 21'(r_rate) * 21'(PKT_FLITS);
                n_q     = (r_now >= r_created) ? r_now - r_created : '0;
                n_sat   = 1'b0;
                n_state = r_mode ? S_MDC : S_FIN;
            end
            S_MDC: begin
                n_c = 26'(r_s) * 26'(r_dim);
                n_state = S_MDCHK;
            end
            S_MDCHK: begin
                if (r_s >= 21'd65536 || r_c >= 26'd262144) begin
                    n_sat = 1'b1;
                    n_wait = WAIT_W'(SATURATED_WAIT);
                    n_state = S_FIN;
                end else begin
                    n_dnum = ((DNW'(r_s) * DNW'(PKT_FLITS)) << 16) + w_s_half;
                    n_den  = DENW'(w_s_half << 1);
                    n_drem = '0;
                    n_dcnt = '0;
                    n_state = S_DIVS;
                end
            end
            S_DIVS: begin
                n_dnum = w_dnum_nx;
                n_drem = w_drem_nx;
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == DIV_LAST) begin
                    n_ws   = w_dnum_nx;
                    n_dnum = w_wc_num;
                    n_den  = DENW'(w_c_half << 1);
                    n_drem = '0;
                    n_dcnt = '0;
                    n_state = S_DIVC;
                end
            end
            S_DIVC: begin
                n_dnum = w_dnum_nx;
                n_drem = w_drem_nx;
                n_dcnt = r_dcnt + 6'd1;
                if (r_dcnt == DIV_LAST) begin
                    n_wc = w_dnum_nx;
                    n_state = S_MDMUL;
                end
            end
            S_MDMUL: begin
                n_hwc = 45'(r_hops) * 45'(r_wc);
                n_state = S_MDWAIT;
            end
            S_MDWAIT: begin
                n_wait = w_wsum[45:16];
                n_state = S_FIN;
            end
            S_FIN: begin
                n_lat = (w_full > 49'h0_FFFF_FFFF) ? '1 : w_full[31:0];
                n_arr = w_arr[48] ? '1 : w_arr[47:0];
                n_state = S_OUT;
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_out_v  = 1'b1;
                    n_o_node = r_node;
                    n_o_lat  = r_lat;
                    n_o_sat  = r_sat;
                    n_o_tot  = r_sum_lat;
                    n_o_cnt  = r_sum_del;
                    n_o_last = 1'b1;
                    if (r_cnt == CW'(QUEUE_DEPTH)) begin
                        n_o_kind = KIND_DROPPED;
                        n_state = S_IDLE;
                    end else begin
                        n_o_kind = KIND_ACCEPTED;
                        n_x = '{arrival: r_arr, latency: r_lat, node: r_node, stamp: r_stamp};
                        n_stamp = r_stamp + STAMP_W'(1);
                        n_i = r_cnt[AW-1:0];
                        n_cnt = r_cnt + CW'(1);
                        n_state = S_SURD;
                    end
                end
            end
            S_SURD: begin
                if (r_i == '0) begin
                    w_we = 1'b1;
                    n_state = S_IDLE;
                end else begin
                    w_raddr = w_par;
                    n_state = S_SUCMP;
                end
            end
            S_SUCMP: begin
                w_we = 1'b1;
                if (earlier(r_x, w_rdata)) begin
                    w_wdata = w_rdata;
                    n_i = w_par;
                    n_state = S_SURD;
                end else begin
                    n_state = S_IDLE;
                end
            end
            S_POPRD: begin
                n_state = S_POPCMP;
            end
            S_POPCMP: begin
                if (w_due) begin
                    if (!r_pv || w_out_free) begin
                        if (r_pv) begin
                            n_out_v  = 1'b1;
                            n_o_kind = KIND_DELIVERED;
                            n_o_node = r_p_node;
                            n_o_lat  = r_p_lat;
                            n_o_sat  = 1'b0;
                            n_o_tot  = r_p_tot;
                            n_o_cnt  = r_p_cnt;
                            n_o_last = 1'b0;
                        end
                        n_sum_lat = r_sum_lat + SUM_W'(w_rdata.latency);
                        n_sum_del = r_sum_del + SUM_W'(1);
                        n_p_node = w_rdata.node;
                        n_p_lat  = w_rdata.latency;
                        n_p_tot  = n_sum_lat;
                        n_p_cnt  = n_sum_del;
                        n_pv = 1'b1;
                        n_npop = r_npop + 7'd1;
                        n_cnt = r_cnt - CW'(1);
                        n_state = (r_cnt == CW'(1)) ? S_POPRD : S_POPLAST;
                    end
                end else begin
                    n_state = r_pv ? S_FLUSH : S_IDLE;
                end
            end
            S_POPLAST: begin
                w_raddr = r_cnt[AW-1:0];
                n_state = S_SDX;
            end
            S_SDX: begin
                n_x = w_rdata;
                n_i = '0;
                n_state = S_SDL;
            end
            S_SDL: begin
                if ((CW+1)'(w_l) >= (CW+1)'(r_cnt)) begin
                    w_we = 1'b1;
                    n_state = S_POPRD;
                end else begin
                    w_raddr = w_l[AW-1:0];
                    n_state = S_SDR;
                end
            end
            S_SDR: begin
                n_lc = w_rdata;
                n_hasr = (CW+1)'(w_r) < (CW+1)'(r_cnt);
                w_raddr = w_r[AW-1:0];
                n_state = S_SDCMP;
            end
            S_SDCMP: begin
                w_we = 1'b1;
                if (w_rbest) begin
                    w_wdata = w_rdata;
                    n_i = w_r[AW-1:0];
                    n_state = S_SDL;
                end else if (w_lbest) begin
                    w_wdata = r_lc;
                    n_i = w_l[AW-1:0];
                    n_state = S_SDL;
                end else begin
                    n_state = S_POPRD;
                end
            end
            S_FLUSH: begin
                if (w_out_free) begin
                    n_out_v  = 1'b1;
                    n_o_kind = KIND_DELIVERED;
                    n_o_node = r_p_node;
                    n_o_lat  = r_p_lat;
                    n_o_sat  = 1'b0;
                    n_o_tot  = r_p_tot;
                    n_o_cnt  = r_p_cnt;
                    n_o_last = 1'b1;
                    n_pv = 1'b0;
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_mode <= MODE_RST; r_dim <= DIM_RST; r_phd <= HOP_RST; r_rate <= RATE_RST;
            r_cnt <= '0; r_stamp <= '0; r_sum_lat <= '0; r_sum_del <= '0;
            r_out_v <= 1'b0; r_pv <= 1'b0; r_npop <= '0; r_dcnt <= '0;
        end else begin
            r_state <= n_state;
            r_mode <= n_mode; r_dim <= n_dim; r_phd <= n_phd; r_rate <= n_rate;
            r_cnt <= n_cnt; r_stamp <= n_stamp; r_sum_lat <= n_sum_lat; r_sum_del <= n_sum_del;
            r_out_v <= n_out_v; r_pv <= n_pv; r_npop <= n_npop; r_dcnt <= n_dcnt;
        end
        r_sc <= n_sc; r_sr <= n_sr; r_dc <= n_dc; r_dr <= n_dr;
        r_created <= n_created; r_now <= n_now; r_q <= n_q; r_arr <= n_arr;
        r_hops <= n_hops; r_node <= n_node; r_delay <= n_delay; r_s <= n_s; r_c <= n_c;
        r_sat <= n_sat; r_dnum <= n_dnum; r_ws <= n_ws; r_wc <= n_wc; r_drem <= n_drem;
        r_den <= n_den; r_hwc <= n_hwc; r_wait <= n_wait; r_lat <= n_lat;
        r_x <= n_x; r_lc <= n_lc; r_i <= n_i; r_hasr <= n_hasr;
        r_p_node <= n_p_node; r_p_lat <= n_p_lat; r_p_tot <= n_p_tot; r_p_cnt <= n_p_cnt;
        r_o_kind <= n_o_kind; r_o_node <= n_o_node; r_o_lat <= n_o_lat; r_o_sat <= n_o_sat;
        r_o_last <= n_o_last; r_o_tot <= n_o_tot; r_o_cnt <= n_o_cnt;
    end

endmodule

// ===== hdl/nlcq_checker.sv =====
// port-level checker of the noc latency completion queue, bound to the top level
// depends on nlcq_pkg and noc_latency_completion_queue_macros.svh
`include "noc_latency_completion_queue_macros.svh"

module nlcq_checker
    import nlcq_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [111:0] i_s_tdata,
    input logic         i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [143:0] o_m_tdata,
    input logic [1:0]   o_m_tuser,
    input logic         o_m_tlast,
    input logic         i_psel,
    input logic         i_penable,
    input logic         i_pwrite,
    input logic [3:0]   i_paddr,
    input logic [31:0]  i_pwdata,
    input logic [31:0]  o_prdata,
    input logic         o_pready
);

    `NLCQ_ASSERT_NEXT(a_busy_after_take, i_s_tvalid && o_s_tready, !o_s_tready, "ready after transfer")
    `NLCQ_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata), "output dropped while stalled")
    `NLCQ_ASSERT_NOW(a_deliv_unsat, o_m_tvalid && o_m_tuser == KIND_DELIVERED, !o_m_tdata[40], "delivered result flagged saturated")
    `NLCQ_ASSERT_NOW(a_inject_last, o_m_tvalid && o_m_tuser != KIND_DELIVERED, o_m_tlast, "inject result not last")

endmodule

bind noc_latency_completion_queue nlcq_checker u_nlcq_checker (.*);
